[src/ifrt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ifrt_pkg
// shared types, constants and helpers of the ipv6 fragment reassembly tracker
// ----------------------------------------------------------------------------
package ifrt_pkg;

  localparam int CONTEXTS   = 4;
  localparam int MAX_BLOCKS = 64;
  localparam int CTX_W      = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int BLK_NUM_W  = 14;  // fragment offset plus block count
  localparam int SLOT_W     = 2;
  localparam int MASK_W     = 4;

  localparam logic [7:0] FRAG_HDR_RESET = 8'd8;
  localparam logic [7:0] TIMER_RESET    = 8'd15;

  typedef enum logic [2:0] {
    ST_WHOLE = 3'd0,
    ST_HELD  = 3'd1,
    ST_DONE  = 3'd2,
    ST_FULL  = 3'd3,
    ST_BAD   = 3'd4,
    ST_TICK  = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    CFG_FRAG_HDR = 1'b0,
    CFG_TIMER    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC
  } fsm_t;

  typedef struct packed {
    logic load;    // capture the input item
    logic match;   // register key match and length checks
    logic commit;  // update contexts and write the result
  } cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new item
  } sts_t;

  // bits below n set, all ones once n reaches the table size
  function automatic logic [MAX_BLOCKS-1:0] low_mask(input logic [BLK_NUM_W-1:0] n);
    logic [MAX_BLOCKS-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      m[i] = (BLK_NUM_W'(i) < n);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[src/ifrt_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ifrt_ctrl
// sequencer: accept, match, execute, one item at a time
// ----------------------------------------------------------------------------
module ifrt_ctrl
  import ifrt_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[src/ifrt_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ifrt_dp
// context table, key match, block map update and result register
// ----------------------------------------------------------------------------
module ifrt_dp
  import ifrt_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  wire         wr_en,
  input  wire         wr_index,
  input  wire  [7:0]  wr_data,
  input  wire         func,
  input  wire  [63:0] src_hi,
  input  wire  [63:0] src_lo,
  input  wire  [63:0] dst_hi,
  input  wire  [63:0] dst_lo,
  input  wire  [31:0] ident,
  input  wire  [12:0] frag_offset,
  input  wire         more_frags,
  input  wire  [15:0] payload_length,
  input  wire  [15:0] ext_len,
  input  wire  [7:0]  hop_limit,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  status,
  output logic [SLOT_W-1:0] slot,
  output logic [15:0] data_length,
  output logic [15:0] reassembled_length,
  output logic [MASK_W-1:0] expired_mask,
  output logic        flushed_old
);

  // configuration
  logic [7:0] frag_header_len;
  logic [7:0] timer_lower_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_header_len   <= FRAG_HDR_RESET;
      timer_lower_bound <= TIMER_RESET;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_FRAG_HDR: frag_header_len   <= wr_data;
        CFG_TIMER:    timer_lower_bound <= wr_data;
        default:      ;
      endcase
    end
  end

  // captured item
  logic        r_func;
  logic [63:0] r_src_hi, r_src_lo, r_dst_hi, r_dst_lo;
  logic [31:0] r_ident;
  logic [12:0] r_frag_offset;
  logic        r_more_frags;
  logic [15:0] r_payload_length;
  logic [15:0] r_ext_len;
  logic [7:0]  r_hop_limit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func           <= func;
      r_src_hi         <= src_hi;
      r_src_lo         <= src_lo;
      r_dst_hi         <= dst_hi;
      r_dst_lo         <= dst_lo;
      r_ident          <= ident;
      r_frag_offset    <= frag_offset;
      r_more_frags     <= more_frags;
      r_payload_length <= payload_length;
      r_ext_len        <= ext_len;
      r_hop_limit      <= hop_limit;
    end
  end

  // context table
  logic                  ctx_valid       [CONTEXTS];
  logic [63:0]           key_src_hi      [CONTEXTS];
  logic [63:0]           key_src_lo      [CONTEXTS];
  logic [63:0]           key_dst_hi      [CONTEXTS];
  logic [63:0]           key_dst_lo      [CONTEXTS];
  logic [31:0]           key_ident       [CONTEXTS];
  logic [MAX_BLOCKS-1:0] block_map       [CONTEXTS];
  logic [15:0]           total_len       [CONTEXTS];
  logic [7:0]            ctx_timer       [CONTEXTS];
  logic [7:0]            first_hop_limit [CONTEXTS];

  // match stage
  logic                 hit, free_ok;
  logic [CTX_W-1:0]     hit_idx, free_idx;
  logic [16:0]          hdr_sum;
  logic [15:0]          len;
  logic [16:0]          len_round;
  logic [BLK_NUM_W-1:0] blk_last;
  logic                 bad;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    // descending so the lowest index wins
    for (int i = CONTEXTS - 1; i >= 0; i--) begin
      if (ctx_valid[i] && key_src_hi[i] == r_src_hi && key_src_lo[i] == r_src_lo &&
          key_dst_hi[i] == r_dst_hi && key_dst_lo[i] == r_dst_lo &&
          key_ident[i] == r_ident) begin
        hit     = 1'b1;
        hit_idx = CTX_W'(i);
      end
      if (!ctx_valid[i]) begin
        free_ok  = 1'b1;
        free_idx = CTX_W'(i);
      end
    end
    hdr_sum   = {1'b0, r_ext_len} + 17'(frag_header_len);
    len       = r_payload_length - hdr_sum[15:0];
    len_round = {1'b0, len} + 17'd7;
    blk_last  = {1'b0, r_frag_offset} + len_round[16:3];
    bad       = ({1'b0, r_payload_length} < hdr_sum) ||
                (blk_last > BLK_NUM_W'(MAX_BLOCKS));
  end

  logic                 m_hit, m_free_ok, m_bad;
  logic [CTX_W-1:0]     m_hit_idx, m_free_idx;
  logic [15:0]          m_len;
  logic [BLK_NUM_W-1:0] m_last;

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      m_hit      <= hit;
      m_hit_idx  <= hit_idx;
      m_free_ok  <= free_ok;
      m_free_idx <= free_idx;
      m_len      <= len;
      m_last     <= blk_last;
      m_bad      <= bad;
    end
  end

  // execute stage
  logic [CTX_W-1:0]      sel;
  logic                  alloc;
  logic [MAX_BLOCKS-1:0] base_map, new_map, need_mask;
  logic [15:0]           base_total, new_total;
  logic [7:0]            base_timer, new_timer, base_hop, new_hop;
  logic [16:0]           need_round;
  logic                  complete;
  logic [17:0]           rsum;
  logic                  whole;
  logic                  upd;
  logic                  valid_next [CONTEXTS];
  logic [7:0]            timer_next [CONTEXTS];
  logic [CONTEXTS-1:0]   tick_mask;
  status_t               res_status;
  logic [CTX_W-1:0]      res_slot;
  logic [15:0]           res_dlen, res_rlen;
  logic                  res_flushed;

  always_comb begin
    sel        = m_hit ? m_hit_idx : m_free_idx;
    alloc      = !m_hit;
    base_map   = alloc ? '0 : block_map[sel];
    base_total = alloc ? '0 : total_len[sel];
    base_timer = alloc ? timer_lower_bound : ctx_timer[sel];
    base_hop   = alloc ? '0 : first_hop_limit[sel];

    new_map    = base_map | (low_mask(m_last) & ~low_mask({1'b0, r_frag_offset}));
    new_total  = r_more_frags ? base_total : m_len + {r_frag_offset, 3'b000};
    new_hop    = (r_frag_offset == '0) ? r_hop_limit : base_hop;
    need_round = {1'b0, new_total} + 17'd7;
    need_mask  = low_mask(need_round[16:3]);
    complete   = (new_total != '0) && ((new_map & need_mask) == need_mask);
    new_timer  = ((new_total != '0) && (new_hop > base_timer)) ? new_hop : base_timer;
    rsum       = 18'(new_total) + 18'(r_ext_len) + 18'(frag_header_len);
    whole      = (r_frag_offset == '0) && !r_more_frags;

    upd         = 1'b0;
    tick_mask   = '0;
    res_status  = ST_HELD;
    res_slot    = '0;
    res_dlen    = '0;
    res_rlen    = '0;
    res_flushed = 1'b0;
    for (int i = 0; i < CONTEXTS; i++) begin
      valid_next[i] = ctx_valid[i];
      timer_next[i] = ctx_timer[i];
    end

    if (r_func) begin
      res_status = ST_TICK;
      for (int i = 0; i < CONTEXTS; i++) begin
        if (ctx_valid[i]) begin
          if (ctx_timer[i] <= 8'd1) begin
            valid_next[i] = 1'b0;
            tick_mask[i]  = 1'b1;
          end else begin
            timer_next[i] = ctx_timer[i] - 8'd1;
          end
        end
      end
    end else if (whole) begin
      res_status = ST_WHOLE;
      if (m_hit) begin
        valid_next[m_hit_idx] = 1'b0;
        res_slot              = m_hit_idx;
        res_flushed           = 1'b1;
      end
    end else if (m_bad) begin
      res_status = ST_BAD;
    end else if (!m_hit && !m_free_ok) begin
      res_status = ST_FULL;
    end else begin
      upd             = 1'b1;
      valid_next[sel] = !complete;
      timer_next[sel] = new_timer;
      res_slot        = sel;
      res_dlen        = new_total;
      if (complete) begin
        res_status = ST_DONE;
        res_rlen   = (rsum[17:16] != 2'b00) ? 16'hFFFF : rsum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CONTEXTS; i++) begin
        ctx_valid[i] <= 1'b0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < CONTEXTS; i++) begin
        ctx_valid[i] <= valid_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < CONTEXTS; i++) begin
        ctx_timer[i] <= timer_next[i];
      end
      if (upd) begin
        block_map[sel]       <= new_map;
        total_len[sel]       <= new_total;
        first_hop_limit[sel] <= new_hop;
        if (alloc) begin
          key_src_hi[sel] <= r_src_hi;
          key_src_lo[sel] <= r_src_lo;
          key_dst_hi[sel] <= r_dst_hi;
          key_dst_lo[sel] <= r_dst_lo;
          key_ident[sel]  <= r_ident;
        end
      end
    end
  end

  // result register
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status             <= res_status;
      slot               <= SLOT_W'(res_slot);
      data_length        <= res_dlen;
      reassembled_length <= res_rlen;
      expired_mask       <= MASK_W'(tick_mask);
      flushed_old        <= res_flushed;
    end
  end

endmodule
`default_nettype wire

[src/ipv6_fragment_reassembly_tracker_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_fragment_reassembly_tracker_unit
// an item passes through accept, key match and execute, then the result register
// a new item is accepted only once the three-state sequencer is back in idle;
// the execute step waits while an earlier result is still stalled at the output
// reset (rst, synchronous): all contexts invalid, header length 8, timer 15
// ----------------------------------------------------------------------------
module ipv6_fragment_reassembly_tracker_unit
  import ifrt_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  // configuration write port
  input  wire         wr_en,
  input  wire         wr_index,
  input  wire  [7:0]  wr_data,
  // input item
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         func,
  input  wire  [63:0] src_hi,
  input  wire  [63:0] src_lo,
  input  wire  [63:0] dst_hi,
  input  wire  [63:0] dst_lo,
  input  wire  [31:0] ident,
  input  wire  [12:0] frag_offset,
  input  wire         more_frags,
  input  wire  [15:0] payload_length,
  input  wire  [15:0] ext_len,
  input  wire  [7:0]  hop_limit,
  // result item
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  status,
  output logic [1:0]  slot,
  output logic [15:0] data_length,
  output logic [15:0] reassembled_length,
  output logic [3:0]  expired_mask,
  output logic        flushed_old
);

  // controller steps one item through match and execute; the datapath
  // holds the context table and a result register that decouples the output
  cmd_t cmd;
  sts_t sts;

  ifrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // a tick ages every valid context at once; a fragment touches only its own slot
  ifrt_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .wr_en              (wr_en),
    .wr_index           (wr_index),
    .wr_data            (wr_data),
    .func               (func),
    .src_hi             (src_hi),
    .src_lo             (src_lo),
    .dst_hi             (dst_hi),
    .dst_lo             (dst_lo),
    .ident              (ident),
    .frag_offset        (frag_offset),
    .more_frags         (more_frags),
    .payload_length     (payload_length),
    .ext_len            (ext_len),
    .hop_limit          (hop_limit),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .slot               (slot),
    .data_length        (data_length),
    .reassembled_length (reassembled_length),
    .expired_mask       (expired_mask),
    .flushed_old        (flushed_old)
  );

endmodule
`default_nettype wire
